[hw/rtl/jce_pkg.sv]
// ----------------------------------------------------------------------------
// jce_pkg
// Shared types and constants of the JIS code output encoder.
// ----------------------------------------------------------------------------
package jce_pkg;

  typedef enum logic [1:0] {
    ModePass = 2'd0,
    ModeEuc  = 2'd1,
    ModeSjis = 2'd2,
    ModeIso  = 2'd3
  } out_mode_e;

  localparam int unsigned MaxBytes   = 5;
  localparam int unsigned CntW       = 3;
  localparam int unsigned QueueDepth = 2;

  localparam logic [1:0] CfgOutMode    = 2'd0;
  localparam logic [1:0] CfgAsciiFinal = 2'd1;
  localparam logic [1:0] CfgKanjiFinal = 2'd2;

  localparam logic [7:0]  EscByte     = 8'h1B;
  localparam logic [7:0]  Ss2Byte     = 8'h8E;
  localparam logic [7:0]  DesigAscii  = 8'h28;
  localparam logic [7:0]  DesigKanji  = 8'h24;
  localparam logic [15:0] TwoByteBase = 16'h0100;
  localparam logic [7:0]  FinalReset  = 8'h42;

  localparam logic [7:0] SjisLowRowOff  = 8'h70;
  localparam logic [7:0] SjisHighRowOff = 8'hB0;
  localparam logic [7:0] SjisRowSplit   = 8'h5E;
  localparam logic [7:0] SjisOddLoOff   = 8'h1F;
  localparam logic [7:0] SjisOddHiOff   = 8'h20;
  localparam logic [7:0] SjisOddSplit   = 8'h60;
  localparam logic [7:0] SjisEvenOff    = 8'h7E;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          cnt;
  } byte_seq_t;

endpackage

[hw/rtl/jce_front.sv]
// ----------------------------------------------------------------------------
// jce_front
// Accepts character codes, holds configuration and charset state, and builds
// the byte sequence of each item.
// ----------------------------------------------------------------------------
module jce_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [15:0]         char_code_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i,
  input  logic                q_full_i,
  output logic                push_o,
  output jce_pkg::byte_seq_t  push_seq_o
);

  jce_pkg::out_mode_e out_mode_q;
  logic [7:0]         ascii_final_q;
  logic [7:0]         kanji_final_q;
  logic               charset_q;
  logic               charset_d;
  logic [7:0]         hi;
  logic [7:0]         lo;
  logic               wide;
  logic [8:0]         hi_inc;
  logic [7:0]         s1;
  logic [7:0]         s2;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full_i;
  assign push_o      = in_valid_i && !q_full_i;

  assign hi   = char_code_i[15:8];
  assign lo   = char_code_i[7:0];
  assign wide = char_code_i >= jce_pkg::TwoByteBase;

  assign hi_inc = {1'b0, hi} + 9'd1;
  assign s1 = hi_inc[8:1] + ((hi <= jce_pkg::SjisRowSplit) ?
              jce_pkg::SjisLowRowOff : jce_pkg::SjisHighRowOff);

  always_comb begin
    if (hi[0]) begin
      s2 = lo + ((lo >= jce_pkg::SjisOddSplit) ? jce_pkg::SjisOddHiOff
                                               : jce_pkg::SjisOddLoOff);
    end else begin
      s2 = lo + jce_pkg::SjisEvenOff;
    end
  end

  always_comb begin
    push_seq_o = '0;
    charset_d  = charset_q;
    unique case (out_mode_q)
      jce_pkg::ModePass: begin
        push_seq_o.bytes[0] = lo;
        push_seq_o.cnt      = 3'd1;
      end
      jce_pkg::ModeEuc: begin
        if (wide) begin
          push_seq_o.bytes[0] = hi | 8'h80;
          push_seq_o.bytes[1] = lo | 8'h80;
          push_seq_o.cnt      = 3'd2;
        end else if (lo[7]) begin
          push_seq_o.bytes[0] = jce_pkg::Ss2Byte;
          push_seq_o.bytes[1] = lo;
          push_seq_o.cnt      = 3'd2;
        end else begin
          push_seq_o.bytes[0] = lo;
          push_seq_o.cnt      = 3'd1;
        end
      end
      jce_pkg::ModeSjis: begin
        if (wide) begin
          push_seq_o.bytes[0] = s1;
          push_seq_o.bytes[1] = s2;
          push_seq_o.cnt      = 3'd2;
        end else begin
          push_seq_o.bytes[0] = lo;
          push_seq_o.cnt      = 3'd1;
        end
      end
      jce_pkg::ModeIso: begin
        charset_d = wide;
        if (wide) begin
          if (!charset_q) begin
            push_seq_o.bytes[0] = jce_pkg::EscByte;
            push_seq_o.bytes[1] = jce_pkg::DesigKanji;
            push_seq_o.bytes[2] = kanji_final_q;
            push_seq_o.bytes[3] = hi;
            push_seq_o.bytes[4] = lo;
            push_seq_o.cnt      = 3'd5;
          end else begin
            push_seq_o.bytes[0] = hi;
            push_seq_o.bytes[1] = lo;
            push_seq_o.cnt      = 3'd2;
          end
        end else begin
          if (charset_q) begin
            push_seq_o.bytes[0] = jce_pkg::EscByte;
            push_seq_o.bytes[1] = jce_pkg::DesigAscii;
            push_seq_o.bytes[2] = ascii_final_q;
            push_seq_o.bytes[3] = lo;
            push_seq_o.cnt      = 3'd4;
          end else begin
            push_seq_o.bytes[0] = lo;
            push_seq_o.cnt      = 3'd1;
          end
        end
      end
      default: begin
        push_seq_o.bytes[0] = lo;
        push_seq_o.cnt      = 3'd1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_mode_q    <= jce_pkg::ModeEuc;
      ascii_final_q <= jce_pkg::FinalReset;
      kanji_final_q <= jce_pkg::FinalReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        jce_pkg::CfgOutMode:    out_mode_q    <= jce_pkg::out_mode_e'(cfg_data_i[1:0]);
        jce_pkg::CfgAsciiFinal: ascii_final_q <= cfg_data_i;
        jce_pkg::CfgKanjiFinal: kanji_final_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      charset_q <= 1'b0;
    end else if (push_o) begin
      charset_q <= charset_d;
    end
  end

endmodule

[hw/rtl/jce_queue.sv]
// ----------------------------------------------------------------------------
// jce_queue
// Short FIFO of byte sequences between the front and back parts.
// ----------------------------------------------------------------------------
module jce_queue #(
  parameter int unsigned Depth = jce_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  jce_pkg::byte_seq_t push_seq_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output jce_pkg::byte_seq_t pop_seq_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  jce_pkg::byte_seq_t mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q;
  logic [PtrW-1:0]    rd_ptr_q;
  logic [CntW-1:0]    count_q;
  logic               do_push;
  logic               do_pop;

  assign full_o    = count_q == FullCnt;
  assign valid_o   = count_q != '0;
  assign pop_seq_o = mem_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_seq_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/jce_back.sv]
// ----------------------------------------------------------------------------
// jce_back
// Takes byte sequences from the queue and sends them one byte per item.
// ----------------------------------------------------------------------------
module jce_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  jce_pkg::byte_seq_t q_seq_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic               last_byte_o
);

  logic                       busy_q;
  jce_pkg::byte_seq_t         seq_q;
  logic [jce_pkg::CntW-1:0]   idx_q;
  logic                       out_fire;

  assign out_valid_o = busy_q;
  assign out_byte_o  = seq_q.bytes[idx_q];
  assign last_byte_o = idx_q == (seq_q.cnt - 1'b1);
  assign out_fire    = busy_q && !out_stall_i;
  assign pop_o       = q_valid_i && (!busy_q || (out_fire && last_byte_o));

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      seq_q <= q_seq_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (out_fire) begin
      if (last_byte_o) begin
        busy_q <= 1'b0;
        idx_q  <= '0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (idx_q < seq_q.cnt))
    else $error("byte index beyond sequence length");

  a_cont_after_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !last_byte_o) |=> (out_valid_o && idx_q == $past(idx_q) + 1'b1))
    else $error("sequence broken before its last byte");

  a_restart_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && last_byte_o) |=> (idx_q == '0))
    else $error("new sequence does not start at its first byte");

  a_pop_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (!busy_q || (out_fire && last_byte_o)))
    else $error("sequence loaded while another is in flight");

endmodule

[hw/rtl/jis_code_output_encoder.sv]
// ----------------------------------------------------------------------------
// jis_code_output_encoder
// Encodes internal character codes as EUC-JP, Shift_JIS, ISO-2022-JP or
// pass-through bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_stall_o carries one char_code_i per item.
//   Output channel out_valid_o/out_stall_i carries one byte per item;
//   last_byte_o marks the final byte of a character (1 to 5 bytes each).
//   Configuration writes go through cfg_valid_i/cfg_ready_o with
//   cfg_index_i (0 mode, 1 ASCII final, 2 kanji final) and cfg_data_i;
//   cfg_ready_o is always high. Write only while the block is idle.
// Timing:
//   The first byte of a character is offered once its sequence has passed
//   through the queue and been loaded into the back part's byte register.
//   The byte port sends one byte per cycle while out_stall_i is low; the
//   input is taken every cycle while the queue of QueueDepth sequences
//   has room.
// Reset clears the queue, selects EUC-JP with final bytes 0x42 and marks
// ASCII as designated. A stalled receiver holds the current byte; the
// queue then fills and in_stall_o rises.
// ----------------------------------------------------------------------------
module jis_code_output_encoder #(
  parameter int unsigned QueueDepth = jce_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] char_code_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        last_byte_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  logic               q_full;
  logic               push;
  jce_pkg::byte_seq_t push_seq;
  logic               pop;
  logic               q_valid;
  jce_pkg::byte_seq_t pop_seq;

  jce_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_seq_o  (push_seq)
  );

  jce_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_seq_i (push_seq),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_seq_o  (pop_seq)
  );

  jce_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_seq_i     (pop_seq),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .last_byte_o (last_byte_o)
  );

endmodule

[verif/jis_code_output_encoder_tb.sv]
// ----------------------------------------------------------------------------
// jis_code_output_encoder_tb
// Self-checking bench for the JIS code output encoder. A directed table
// covers the field extremes, every output mode, the 0x100 boundary, the
// Shift_JIS row and column splits and the ISO-2022-JP designation changes,
// including a charset carried across a mode change. Random phases follow
// under several register settings, all but one with random idling on both
// channels. Each byte is checked against typed rows or an in-bench encoder.
// ----------------------------------------------------------------------------
module jis_code_output_encoder_tb;

  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned PhaseItems    = 32;
  localparam int unsigned NumPhases     = 6;
  localparam int unsigned IdlePct       = 38;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } enc_byte_t;

  typedef struct packed {
    jce_pkg::out_mode_e mode;
    logic [7:0]         afin;
    logic [7:0]         kfin;
    logic [15:0]        code;
    int                 n;
    logic [39:0]        bytes;
  } dir_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [15:0] char_code_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        last_byte_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [7:0]  cfg_data_i  = '0;

  jce_pkg::out_mode_e model_mode = jce_pkg::ModeEuc;
  logic [7:0]         model_afin = jce_pkg::FinalReset;
  logic [7:0]         model_kfin = jce_pkg::FinalReset;
  logic               iso_kanji  = 1'b0;

  logic [7:0] enc_bytes [jce_pkg::MaxBytes];
  int         enc_cnt;

  enc_byte_t  pending_bytes [$];
  dir_row_t   dir_tab [$];
  bit         idle_on   = 1'b1;
  int         err_cnt   = 0;
  int         cycle_cnt = 0;

  jis_code_output_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .last_byte_o (last_byte_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("jis_code_output_encoder_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= idle_on && ($urandom_range(99) < IdlePct);
  end

  always @(posedge clk_i) begin
    enc_byte_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: out_byte expected none actual %02h", $time, out_byte_o);
        err_cnt++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_byte_o !== want.data) begin
          $display("%0t: out_byte expected %02h actual %02h", $time, want.data,
                   out_byte_o);
          err_cnt++;
        end
        if (last_byte_o !== want.is_last) begin
          $display("%0t: last_byte expected %0b actual %0b", $time, want.is_last,
                   last_byte_o);
          err_cnt++;
        end
      end
    end
  end

  function automatic void put_byte(input logic [7:0] b);
    enc_bytes[enc_cnt] = b;
    enc_cnt++;
  endfunction

  function automatic void encode_char(input logic [15:0] code);
    logic [7:0] hi;
    logic [7:0] lo;
    logic [8:0] half;
    logic       wide;
    hi   = code[15:8];
    lo   = code[7:0];
    wide = code >= jce_pkg::TwoByteBase;
    half = ({1'b0, hi} + 9'd1) >> 1;
    enc_cnt = 0;
    case (model_mode)
      jce_pkg::ModePass: begin
        put_byte(lo);
      end
      jce_pkg::ModeEuc: begin
        if (wide) begin
          put_byte(hi | 8'h80);
          put_byte(lo | 8'h80);
        end else if (lo[7]) begin
          put_byte(jce_pkg::Ss2Byte);
          put_byte(lo);
        end else begin
          put_byte(lo);
        end
      end
      jce_pkg::ModeSjis: begin
        if (wide) begin
          put_byte(half[7:0] + ((hi <= jce_pkg::SjisRowSplit) ?
                                jce_pkg::SjisLowRowOff : jce_pkg::SjisHighRowOff));
          if (hi[0]) begin
            put_byte(lo + ((lo >= jce_pkg::SjisOddSplit) ? jce_pkg::SjisOddHiOff
                                                         : jce_pkg::SjisOddLoOff));
          end else begin
            put_byte(lo + jce_pkg::SjisEvenOff);
          end
        end else begin
          put_byte(lo);
        end
      end
      default: begin
        if (wide) begin
          if (!iso_kanji) begin
            put_byte(jce_pkg::EscByte);
            put_byte(jce_pkg::DesigKanji);
            put_byte(model_kfin);
            iso_kanji = 1'b1;
          end
          put_byte(hi);
          put_byte(lo);
        end else begin
          if (iso_kanji) begin
            put_byte(jce_pkg::EscByte);
            put_byte(jce_pkg::DesigAscii);
            put_byte(model_afin);
            iso_kanji = 1'b0;
          end
          put_byte(lo);
        end
      end
    endcase
  endfunction

  function automatic void add_row(input jce_pkg::out_mode_e mode,
                                  input logic [7:0] afin, input logic [7:0] kfin,
                                  input logic [15:0] code, input int n,
                                  input logic [39:0] bytes);
    dir_row_t r;
    r.mode  = mode;
    r.afin  = afin;
    r.kfin  = kfin;
    r.code  = code;
    r.n     = n;
    r.bytes = bytes;
    dir_tab.push_back(r);
  endfunction

  function automatic logic [15:0] rand_code();
    int         r;
    logic [7:0] h;
    logic [7:0] l;
    r = $urandom_range(99);
    h = 8'($urandom_range(8'h7E, 8'h21));
    l = 8'($urandom_range(8'h7E, 8'h21));
    if (r < 25) return 16'($urandom_range(8'h7F));
    if (r < 40) return 16'($urandom_range(8'hFF, 8'h80));
    if (r < 80) return {h, l};
    return 16'($urandom);
  endfunction

  // n_typed of zero takes the encoder's bytes; otherwise the typed bytes,
  // last byte in the low octet.
  task automatic send_code(input logic [15:0] code, input int n_typed,
                           input logic [39:0] typed);
    enc_byte_t e;
    while (idle_on && ($urandom_range(99) < IdlePct)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= code;
    do @(posedge clk_i); while (in_stall_o);
    encode_char(code);
    if (n_typed != 0) begin
      for (int i = 0; i < n_typed; i++) begin
        e.data    = typed[(n_typed-1-i)*8 +: 8];
        e.is_last = (i == n_typed - 1);
        pending_bytes.push_back(e);
      end
    end else begin
      for (int i = 0; i < enc_cnt; i++) begin
        e.data    = enc_bytes[i];
        e.is_last = (i == enc_cnt - 1);
        pending_bytes.push_back(e);
      end
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_bytes.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apply_config(input jce_pkg::out_mode_e mode, input logic [7:0] afin,
                              input logic [7:0] kfin);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= jce_pkg::CfgOutMode;
    cfg_data_i  <= {6'd0, mode};
    do @(posedge clk_i); while (!cfg_ready_o);
    model_mode = mode;
    cfg_index_i <= jce_pkg::CfgAsciiFinal;
    cfg_data_i  <= afin;
    do @(posedge clk_i); while (!cfg_ready_o);
    model_afin = afin;
    cfg_index_i <= jce_pkg::CfgKanjiFinal;
    cfg_data_i  <= kfin;
    do @(posedge clk_i); while (!cfg_ready_o);
    model_kfin = kfin;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    jce_pkg::out_mode_e phase_mode [NumPhases];
    jce_pkg::out_mode_e pm;
    logic [7:0]         af;
    logic [7:0]         kf;

    phase_mode = '{jce_pkg::ModeIso, jce_pkg::ModeSjis, jce_pkg::ModePass,
                   jce_pkg::ModeIso, jce_pkg::ModeEuc, jce_pkg::ModeIso};

    add_row(jce_pkg::ModeEuc,  8'h42, 8'h42, 16'h0041, 1, 40'h41);
    add_row(jce_pkg::ModeEuc,  8'h42, 8'h42, 16'h0000, 1, 40'h00);
    add_row(jce_pkg::ModeEuc,  8'h42, 8'h42, 16'h007F, 1, 40'h7F);
    add_row(jce_pkg::ModeEuc,  8'h42, 8'h42, 16'h0080, 2, 40'h8E80);
    add_row(jce_pkg::ModeEuc,  8'h42, 8'h42, 16'h00FF, 2, 40'h8EFF);
    add_row(jce_pkg::ModeEuc,  8'h42, 8'h42, 16'h0100, 2, 40'h8180);
    add_row(jce_pkg::ModeEuc,  8'h42, 8'h42, 16'h3021, 2, 40'hB0A1);
    add_row(jce_pkg::ModeEuc,  8'h42, 8'h42, 16'hFFFF, 2, 40'hFFFF);
    add_row(jce_pkg::ModeEuc,  8'h42, 8'h42, 16'h80A5, 2, 40'h80A5);
    add_row(jce_pkg::ModePass, 8'h42, 8'h42, 16'hFFFF, 1, 40'hFF);
    add_row(jce_pkg::ModePass, 8'h42, 8'h42, 16'h1234, 1, 40'h34);
    add_row(jce_pkg::ModeSjis, 8'h42, 8'h42, 16'h00FF, 1, 40'hFF);
    add_row(jce_pkg::ModeSjis, 8'h42, 8'h42, 16'h3021, 0, 40'h0);
    add_row(jce_pkg::ModeSjis, 8'h42, 8'h42, 16'h5E7E, 0, 40'h0);
    add_row(jce_pkg::ModeSjis, 8'h42, 8'h42, 16'h5F21, 0, 40'h0);
    add_row(jce_pkg::ModeSjis, 8'h42, 8'h42, 16'h2260, 0, 40'h0);
    add_row(jce_pkg::ModeSjis, 8'h42, 8'h42, 16'h2160, 0, 40'h0);
    add_row(jce_pkg::ModeSjis, 8'h42, 8'h42, 16'hFFFF, 0, 40'h0);
    add_row(jce_pkg::ModeSjis, 8'h42, 8'h42, 16'h0100, 0, 40'h0);
    add_row(jce_pkg::ModeIso,  8'h4A, 8'h40, 16'h0041, 1, 40'h41);
    add_row(jce_pkg::ModeIso,  8'h4A, 8'h40, 16'h3021, 5, 40'h1B24403021);
    add_row(jce_pkg::ModeIso,  8'h4A, 8'h40, 16'h3022, 2, 40'h3022);
    add_row(jce_pkg::ModeIso,  8'h4A, 8'h40, 16'h0000, 4, 40'h1B284A00);
    add_row(jce_pkg::ModeIso,  8'h00, 8'hFF, 16'h0100, 5, 40'h1B24FF0100);
    add_row(jce_pkg::ModeEuc,  8'h00, 8'hFF, 16'h0041, 1, 40'h41);
    add_row(jce_pkg::ModeIso,  8'hFF, 8'hFF, 16'h0041, 4, 40'h1B28FF41);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].mode != model_mode || dir_tab[i].afin != model_afin ||
          dir_tab[i].kfin != model_kfin) begin
        drain();
        apply_config(dir_tab[i].mode, dir_tab[i].afin, dir_tab[i].kfin);
      end
      send_code(dir_tab[i].code, dir_tab[i].n, dir_tab[i].bytes);
    end

    for (int p = 0; p < NumPhases; p++) begin
      pm = phase_mode[p];
      af = 8'($urandom_range(255));
      kf = 8'($urandom_range(255));
      if (p == 0) begin
        af = 8'h00;
        kf = 8'hFF;
      end else if (p == 3) begin
        af = 8'hFF;
        kf = 8'h00;
      end
      drain();
      apply_config(pm, af, kf);
      idle_on = (p != 2);
      for (int k = 0; k < PhaseItems; k++) begin
        if (p == 3 && k == PhaseItems / 2) drain();
        send_code(rand_code(), 0, 40'h0);
      end
    end
    idle_on = 1'b1;

    drain();
    if (err_cnt == 0) begin
      $display("jis_code_output_encoder_tb: done, clean");
    end else begin
      $display("jis_code_output_encoder_tb: done, errors");
    end
    $finish;
  end

endmodule
